@@ hdl/edf_pkg.sv @@
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types, sizes and helpers for the EDF task scheduler table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edf_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int TIME_BITS  = 16;
  localparam int IDXW       = $clog2(TASK_SLOTS);
  // index compare width: holds TASK_SLOTS and any 4-bit target
  localparam int CMPW       = ((IDXW > 4) ? IDXW : 4) + 1;

  typedef logic [IDXW-1:0]      idx_t;
  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t TIME_ONES = '1;

  typedef enum logic [1:0] {
    ST_DORMANT  = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_state_t;

  typedef enum logic [3:0] {
    REQ_CREATE       = 4'd0,
    REQ_START        = 4'd1,
    REQ_SCHEDULE     = 4'd2,
    REQ_SET_DEADLINE = 4'd3,
    REQ_YIELD        = 4'd4,
    REQ_PERIOD_YIELD = 4'd5,
    REQ_SLEEP        = 4'd6,
    REQ_EXIT         = 4'd7,
    REQ_INFO         = 4'd8
  } req_code_t;

  // broadcast to every cell during a scan
  typedef struct packed {
    logic [3:0] tgt;
    idx_t       cur;
    logic       cur_known;
    logic       sched;
  } scan_ctl_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic        dorm_found;
    idx_t        dorm_idx;
    logic        best_found;
    idx_t        best_idx;
    time_t       best_dl;
    logic        any_other;
    slot_state_t tgt_state;
    time_t       tgt_dl_left;
    time_t       tgt_dl_init;
    time_t       tgt_sl_left;
    time_t       cur_dl;
    logic        cur_run;
  } scan_t;

  localparam scan_t SCAN_INIT = '{
    dorm_found:  1'b0,
    dorm_idx:    '0,
    best_found:  1'b0,
    best_idx:    '0,
    best_dl:     '0,
    any_other:   1'b0,
    tgt_state:   ST_DORMANT,
    tgt_dl_left: '0,
    tgt_dl_init: '0,
    tgt_sl_left: '0,
    cur_dl:      '0,
    cur_run:     1'b0
  };

  // table update, applied by every cell to its own slot
  typedef struct packed {
    logic        st_a_en;
    idx_t        st_a_idx;
    slot_state_t st_a_val;
    logic        st_b_en;
    idx_t        st_b_idx;
    slot_state_t st_b_val;
    logic        dl_en;
    idx_t        dl_idx;
    time_t       dl_val;
    logic        rl_en;
    idx_t        rl_idx;
    logic        sl_en;
    idx_t        sl_idx;
    time_t       sl_val;
  } slot_cmd_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  running_task;
    logic        running_valid;
    logic        preempt;
    logic        resched_wanted;
    logic [3:0]  result_task;
    logic [1:0]  result_state;
    logic [15:0] result_deadline_left;
    logic [15:0] result_deadline_init;
    logic [15:0] result_sleep_left;
  } rsp_t;

  function automatic time_t sat_in(input logic [15:0] v);
    return (33'(v) > 33'(TIME_ONES)) ? TIME_ONES : TIME_BITS'(v);
  endfunction

  function automatic logic [15:0] sat_out(input time_t v);
    return (33'(v) > 33'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [3:0] idx_nib(input idx_t v);
    logic [CMPW-1:0] w;
    w = CMPW'(v);
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/edf_req_if.sv @@
// ----------------------------------------------------------------------------
// edf_req_if
// Request channel: valid/ready handshake with the kernel call payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface edf_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [3:0]  target_task;
  logic [15:0] deadline_ms;
  logic [15:0] sleep_ms;

  modport source (output valid, req_type, target_task, deadline_ms, sleep_ms,
                  input ready);
  modport sink (input valid, req_type, target_task, deadline_ms, sleep_ms,
                output ready);
endinterface

`default_nettype wire

@@ hdl/edf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// edf_rsp_if
// Response channel: valid/ready handshake with the call result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface edf_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  running_task;
  logic        running_valid;
  logic        preempt;
  logic        resched_wanted;
  logic [3:0]  result_task;
  logic [1:0]  result_state;
  logic [15:0] result_deadline_left;
  logic [15:0] result_deadline_init;
  logic [15:0] result_sleep_left;

  modport source (output valid, status, running_task, running_valid, preempt,
                  resched_wanted, result_task, result_state, result_deadline_left,
                  result_deadline_init, result_sleep_left,
                  input ready);
  modport sink (input valid, status, running_task, running_valid, preempt,
                resched_wanted, result_task, result_state, result_deadline_left,
                result_deadline_init, result_sleep_left,
                output ready);
endinterface

`default_nettype wire

@@ hdl/edf_cell.sv @@
// ----------------------------------------------------------------------------
// edf_cell
// One task slot: holds state and times, folds itself into the scan carry
// when the scan reaches it, and applies broadcast table updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edf_cell (
  input  logic              clk,
  input  logic              rst,
  input  edf_pkg::idx_t     cell_idx,
  input  edf_pkg::idx_t     scan_pos,
  input  logic              scan_en,
  input  edf_pkg::scan_ctl_t ctl,
  input  edf_pkg::scan_t    carry_in,
  output edf_pkg::scan_t    carry_out,
  input  edf_pkg::slot_cmd_t cmd
);
  import edf_pkg::*;

  slot_state_t state, state_next;
  time_t       dl_left, dl_left_next;
  time_t       dl_init, dl_init_next;
  time_t       sl_left, sl_left_next;
  scan_t       carry_next;
  logic        is_cur;
  logic        is_tgt;
  logic        rdy;

  assign is_cur = ctl.cur_known && (cell_idx == ctl.cur);
  assign is_tgt = CMPW'(cell_idx) == CMPW'(ctl.tgt);

  always_comb begin
    carry_next = carry_in;
    rdy = (cell_idx != '0) &&
          ((state == ST_READY) || (ctl.sched && is_cur && state == ST_RUNNING));
    if (cell_idx != '0 && state == ST_DORMANT && !carry_in.dorm_found) begin
      carry_next.dorm_found = 1'b1;
      carry_next.dorm_idx   = cell_idx;
    end
    if (rdy && (!carry_in.best_found || dl_left < carry_in.best_dl)) begin
      carry_next.best_found = 1'b1;
      carry_next.best_idx   = cell_idx;
      carry_next.best_dl    = dl_left;
    end
    if (state != ST_DORMANT && cell_idx != ctl.cur) begin
      carry_next.any_other = 1'b1;
    end
    if (is_tgt) begin
      carry_next.tgt_state   = state;
      carry_next.tgt_dl_left = dl_left;
      carry_next.tgt_dl_init = dl_init;
      carry_next.tgt_sl_left = sl_left;
    end
    if (cell_idx == ctl.cur) begin
      carry_next.cur_dl  = dl_left;
      carry_next.cur_run = (state == ST_RUNNING);
    end
  end

  always_comb begin
    state_next   = state;
    dl_left_next = dl_left;
    dl_init_next = dl_init;
    sl_left_next = sl_left;
    if (cmd.st_b_en && cmd.st_b_idx == cell_idx) begin
      state_next = cmd.st_b_val;
    end else if (cmd.st_a_en && cmd.st_a_idx == cell_idx) begin
      state_next = cmd.st_a_val;
    end
    if (cmd.dl_en && cmd.dl_idx == cell_idx) begin
      dl_left_next = cmd.dl_val;
      dl_init_next = cmd.dl_val;
    end
    if (cmd.rl_en && cmd.rl_idx == cell_idx) begin
      dl_left_next = dl_init;
    end
    if (cmd.sl_en && cmd.sl_idx == cell_idx) begin
      sl_left_next = cmd.sl_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_DORMANT;
      dl_left <= TIME_ONES;
      dl_init <= TIME_ONES;
      sl_left <= TIME_ONES;
    end else begin
      state   <= state_next;
      dl_left <= dl_left_next;
      dl_init <= dl_init_next;
      sl_left <= sl_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_en && scan_pos == cell_idx) begin
      carry_out <= carry_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/edf_task_scheduler_table_core.sv @@
// ----------------------------------------------------------------------------
// edf_task_scheduler_table_core
// Earliest-deadline-first task table built as a row of slot cells.
// ----------------------------------------------------------------------------
// From acceptance to a valid response, a request passes these steps: the
// accepting edge captures the request, the scan carry walks the row of slot
// cells one cell per cycle, and the commit updates the table and loads the
// response register. Requests are handled one at a time; the request channel
// reopens the cycle after the commit. A new request is taken while the
// previous response still waits; its commit then stalls until that response
// has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edf_task_scheduler_table_core (
  input logic       clk,
  input logic       rst,
  edf_req_if.sink   req,
  edf_rsp_if.source rsp
);
  import edf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} fsm_t;

  fsm_t        fsm;
  idx_t        pos;
  logic [3:0]  rq_type;
  logic [3:0]  rq_tgt;
  time_t       rq_dl;
  time_t       rq_sl;
  idx_t        cur;
  logic        cur_known;
  logic        started;
  logic        rsp_valid;
  rsp_t        rsp_q;

  scan_ctl_t   ctl;
  scan_t       carry [TASK_SLOTS];
  scan_t       fin;
  slot_cmd_t   cmd;
  slot_cmd_t   cmd_calc;
  rsp_t        rsp_calc;
  idx_t        cur_next;
  logic        cur_known_next;
  logic        started_next;
  logic        commit;
  logic        scan_en;
  idx_t        pick;
  idx_t        tgt_idx;
  logic        tgt_ok;
  logic        err;

  function automatic logic beats(input logic st, input logic ck, input idx_t c,
                                 input idx_t slot, input time_t dl, input time_t cdl);
    return st && ck && (slot != c) && ((dl < cdl) || (dl == cdl && slot < c));
  endfunction

  assign req.ready = (fsm == S_IDLE);
  assign scan_en   = (fsm == S_SCAN);
  assign commit    = (fsm == S_COMMIT) && (!rsp_valid || rsp.ready);

  assign ctl.tgt       = rq_tgt;
  assign ctl.cur       = cur;
  assign ctl.cur_known = cur_known;
  assign ctl.sched     = (rq_type == REQ_SCHEDULE);

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    edf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (IDXW'(i)),
      .scan_pos (pos),
      .scan_en  (scan_en),
      .ctl      (ctl),
      .carry_in ((i == 0) ? SCAN_INIT : carry[(i == 0) ? 0 : i - 1]),
      .carry_out(carry[i]),
      .cmd      (cmd)
    );
  end

  assign fin     = carry[TASK_SLOTS-1];
  assign pick    = fin.best_found ? fin.best_idx : '0;
  assign tgt_idx = IDXW'(CMPW'(rq_tgt));
  assign tgt_ok  = CMPW'(rq_tgt) < CMPW'(TASK_SLOTS);
  assign cmd     = commit ? cmd_calc : '0;

  always_comb begin
    cmd_calc       = '0;
    rsp_calc       = '0;
    cur_next       = cur;
    cur_known_next = cur_known;
    started_next   = started;
    err            = 1'b0;
    unique case (req_code_t'(rq_type))
      REQ_CREATE: begin
        if (rq_dl == '0 || !fin.dorm_found) begin
          err = 1'b1;
        end else begin
          cmd_calc.st_a_en  = 1'b1;
          cmd_calc.st_a_idx = fin.dorm_idx;
          cmd_calc.st_a_val = ST_READY;
          cmd_calc.dl_en    = 1'b1;
          cmd_calc.dl_idx   = fin.dorm_idx;
          cmd_calc.dl_val   = rq_dl;
          rsp_calc.preempt  = beats(started, cur_known, cur, fin.dorm_idx, rq_dl,
                                    fin.cur_dl);
          rsp_calc.result_task = idx_nib(fin.dorm_idx);
        end
      end
      REQ_START: begin
        if (started) begin
          err = 1'b1;
        end else begin
          cmd_calc.st_a_en  = 1'b1;
          cmd_calc.st_a_idx = '0;
          cmd_calc.st_a_val = ST_READY;
          cmd_calc.st_b_en  = 1'b1;
          cmd_calc.st_b_idx = pick;
          cmd_calc.st_b_val = ST_RUNNING;
          cur_next          = pick;
          cur_known_next    = 1'b1;
          started_next      = 1'b1;
        end
      end
      REQ_SCHEDULE: begin
        if (!started) begin
          err = 1'b1;
        end else begin
          cmd_calc.st_a_en  = cur_known && fin.cur_run;
          cmd_calc.st_a_idx = cur;
          cmd_calc.st_a_val = ST_READY;
          cmd_calc.st_b_en  = 1'b1;
          cmd_calc.st_b_idx = pick;
          cmd_calc.st_b_val = ST_RUNNING;
          cur_next          = pick;
          cur_known_next    = 1'b1;
        end
      end
      REQ_SET_DEADLINE: begin
        if (rq_tgt == '0 || !tgt_ok || rq_dl == '0 || fin.tgt_state != ST_READY) begin
          err = 1'b1;
        end else begin
          cmd_calc.dl_en   = 1'b1;
          cmd_calc.dl_idx  = tgt_idx;
          cmd_calc.dl_val  = rq_dl;
          rsp_calc.preempt = beats(started, cur_known, cur, tgt_idx, rq_dl, fin.cur_dl);
        end
      end
      REQ_YIELD: begin
        if (!started) begin
          err = 1'b1;
        end else begin
          cmd_calc.rl_en          = 1'b1;
          cmd_calc.rl_idx         = cur;
          rsp_calc.resched_wanted = 1'b1;
        end
      end
      REQ_PERIOD_YIELD, REQ_SLEEP: begin
        if (!started) begin
          err = 1'b1;
        end else begin
          cmd_calc.sl_val = (rq_type == REQ_SLEEP) ? rq_sl : fin.cur_dl;
          if (cmd_calc.sl_val != '0 && cur != '0) begin
            cmd_calc.st_a_en        = 1'b1;
            cmd_calc.st_a_idx       = cur;
            cmd_calc.st_a_val       = ST_SLEEPING;
            cmd_calc.sl_en          = 1'b1;
            cmd_calc.sl_idx         = cur;
            rsp_calc.resched_wanted = 1'b1;
          end
        end
      end
      REQ_EXIT: begin
        if (!started) begin
          err = 1'b1;
        end else begin
          cmd_calc.st_a_en        = 1'b1;
          cmd_calc.st_a_idx       = cur;
          cmd_calc.st_a_val       = ST_DORMANT;
          rsp_calc.resched_wanted = fin.any_other;
        end
      end
      REQ_INFO: begin
        if (!tgt_ok || fin.tgt_state == ST_DORMANT) begin
          err = 1'b1;
        end else begin
          rsp_calc.result_task          = rq_tgt;
          rsp_calc.result_state         = fin.tgt_state;
          rsp_calc.result_deadline_left = sat_out(fin.tgt_dl_left);
          rsp_calc.result_deadline_init = sat_out(fin.tgt_dl_init);
          rsp_calc.result_sleep_left    = sat_out(fin.tgt_sl_left);
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (err) begin
      cmd_calc = '0;
      rsp_calc = '0;
    end
    rsp_calc.status        = err;
    rsp_calc.running_task  = idx_nib(cur_next);
    rsp_calc.running_valid = cur_known_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      pos       <= '0;
      cur       <= '0;
      cur_known <= 1'b0;
      started   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (fsm)
        S_IDLE: begin
          if (req.valid) begin
            rq_type <= req.req_type;
            rq_tgt  <= req.target_task;
            rq_dl   <= sat_in(req.deadline_ms);
            rq_sl   <= sat_in(req.sleep_ms);
            pos     <= '0;
            fsm     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (pos == IDXW'(TASK_SLOTS - 1)) begin
            fsm <= S_COMMIT;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            cur       <= cur_next;
            cur_known <= cur_known_next;
            started   <= started_next;
            rsp_q     <= rsp_calc;
            fsm       <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid                = rsp_valid;
  assign rsp.status               = rsp_q.status;
  assign rsp.running_task         = rsp_q.running_task;
  assign rsp.running_valid        = rsp_q.running_valid;
  assign rsp.preempt              = rsp_q.preempt;
  assign rsp.resched_wanted       = rsp_q.resched_wanted;
  assign rsp.result_task          = rsp_q.result_task;
  assign rsp.result_state         = rsp_q.result_state;
  assign rsp.result_deadline_left = rsp_q.result_deadline_left;
  assign rsp.result_deadline_init = rsp_q.result_deadline_init;
  assign rsp.result_sleep_left    = rsp_q.result_sleep_left;

endmodule

`default_nettype wire

@@ hdl/edf_sched_checker.sv @@
// ----------------------------------------------------------------------------
// edf_sched_checker
// Port-level checks for the EDF task scheduler table, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edf_sched_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_status,
  input logic       rsp_preempt,
  input logic       rsp_resched,
  input logic [3:0] rsp_result_task
);

  // a waiting response keeps its content
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_task))
    else $error("response dropped or changed while stalled");

  // one transaction in flight: intake closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_preempt && rsp_resched))
    else $error("preempt and reschedule both set");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> !rsp_preempt && !rsp_resched &&
      rsp_result_task == 4'd0)
    else $error("error response carries result fields");

endmodule

bind edf_task_scheduler_table_core edf_sched_checker u_edf_sched_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_preempt    (rsp.preempt),
  .rsp_resched    (rsp.resched_wanted),
  .rsp_result_task(rsp.result_task)
);

`default_nettype wire

@@ sim/edf_task_scheduler_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// edf_task_scheduler_table_core_tb
// Self-checking testbench for the EDF task scheduler table.
// ----------------------------------------------------------------------------
// Drives kernel calls over the request channel and checks every response
// against a local EDF table model updated at request acceptance. A short
// scripted sequence walks the error paths, preemption, exit of the last task
// and idle fallback; randomized calls with biased targets follow in three
// traffic phases, including a long response hold-off and full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edf_task_scheduler_table_core_tb;
  import edf_pkg::*;

  localparam int          LIMIT_CYCLES   = 200_000;
  localparam int          PHASE_CALLS    = 150;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          HOLD_CYCLES    = 300;
  localparam logic [3:0]  REQ_UNUSED_LO  = 4'd9;
  localparam logic [3:0]  REQ_UNUSED_HI  = 4'd15;

  typedef struct {
    logic [3:0]  kind;
    logic [3:0]  tgt;
    logic [15:0] dl;
    logic [15:0] sl;
    bit          fixed;
    rsp_t        want;
  } call_t;

  logic clk = 1'b0;
  logic rst;

  edf_req_if req ();
  edf_rsp_if rsp ();

  edf_task_scheduler_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler table model
  slot_state_t slot_st [TASK_SLOTS];
  time_t       dl_left [TASK_SLOTS];
  time_t       dl_init [TASK_SLOTS];
  time_t       sl_left [TASK_SLOTS];
  idx_t        cur_slot;
  bit          cur_known;
  bit          started;

  rsp_t  pending_results[$];
  call_t script[$];
  int    errors;
  int    tx_idle_pct;
  int    rx_idle_pct;
  int    rx_hold_req;
  int    rx_hold_left;
  rsp_t  head;

  function automatic idx_t earliest_ready();
    idx_t best;
    bit   found;
    best  = '0;
    found = 1'b0;
    for (int i = 1; i < TASK_SLOTS; i++) begin
      if (slot_st[i] == ST_READY && (!found || dl_left[i] < dl_left[best])) begin
        best  = idx_t'(i);
        found = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic bit beats_running(idx_t slot, time_t d);
    if (!started || !cur_known) return 1'b0;
    return d < dl_left[cur_slot] || (d == dl_left[cur_slot] && slot < cur_slot);
  endfunction

  function automatic bit enter_sleep(time_t t);
    if (t == '0 || cur_slot == '0) return 1'b0;
    slot_st[cur_slot] = ST_SLEEPING;
    sl_left[cur_slot] = t;
    return 1'b1;
  endfunction

  task automatic compute_call_result(input call_t c, output rsp_t r);
    bit    err;
    bit    any;
    idx_t  slot;
    idx_t  t;
    time_t d;
    time_t s;
    r    = '0;
    err  = 1'b0;
    d    = time_t'(c.dl);
    s    = time_t'(c.sl);
    t    = idx_t'(c.tgt);
    if (!started && (c.kind == REQ_SCHEDULE || c.kind == REQ_YIELD ||
                     c.kind == REQ_PERIOD_YIELD || c.kind == REQ_SLEEP ||
                     c.kind == REQ_EXIT)) begin
      err = 1'b1;
    end else begin
      case (c.kind)
        REQ_CREATE: begin
          slot = '0;
          for (int i = TASK_SLOTS - 1; i >= 1; i--)
            if (slot_st[i] == ST_DORMANT) slot = idx_t'(i);
          if (d == '0 || slot == '0) begin
            err = 1'b1;
          end else begin
            slot_st[slot]    = ST_READY;
            dl_init[slot]    = d;
            dl_left[slot]    = d;
            r.preempt        = beats_running(slot, d);
            r.result_task    = 4'(slot);
          end
        end
        REQ_START: begin
          if (started) begin
            err = 1'b1;
          end else begin
            slot_st[0]     = ST_READY;
            cur_slot       = earliest_ready();
            slot_st[cur_slot] = ST_RUNNING;
            cur_known      = 1'b1;
            started        = 1'b1;
          end
        end
        REQ_SCHEDULE: begin
          if (cur_known && slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
          cur_slot          = earliest_ready();
          slot_st[cur_slot] = ST_RUNNING;
          cur_known         = 1'b1;
        end
        REQ_SET_DEADLINE: begin
          if (c.tgt == 4'd0 || 32'(c.tgt) >= TASK_SLOTS || d == '0 ||
              slot_st[t] != ST_READY) begin
            err = 1'b1;
          end else begin
            dl_left[t] = d;
            dl_init[t] = d;
            r.preempt  = beats_running(t, d);
          end
        end
        REQ_YIELD: begin
          dl_left[cur_slot] = dl_init[cur_slot];
          r.resched_wanted  = 1'b1;
        end
        REQ_PERIOD_YIELD: r.resched_wanted = enter_sleep(dl_left[cur_slot]);
        REQ_SLEEP:        r.resched_wanted = enter_sleep(s);
        REQ_EXIT: begin
          slot_st[cur_slot] = ST_DORMANT;
          any = 1'b0;
          for (int i = 0; i < TASK_SLOTS; i++)
            if (slot_st[i] != ST_DORMANT) any = 1'b1;
          r.resched_wanted = any;
        end
        REQ_INFO: begin
          if (32'(c.tgt) >= TASK_SLOTS || slot_st[t] == ST_DORMANT) begin
            err = 1'b1;
          end else begin
            r.result_task          = 4'(t);
            r.result_state         = 2'(slot_st[t]);
            r.result_deadline_left = 16'(dl_left[t]);
            r.result_deadline_init = 16'(dl_init[t]);
            r.result_sleep_left    = 16'(sl_left[t]);
          end
        end
        default: err = 1'b1;
      endcase
    end
    if (err) r = '0;
    r.status        = err;
    r.running_task  = 4'(cur_slot);
    r.running_valid = cur_known;
  endtask

  function automatic rsp_t reply(logic st, logic [3:0] rt, logic rv, logic [3:0] task_id,
                                 slot_state_t qs, logic [15:0] dleft, logic [15:0] dinit,
                                 logic [15:0] sleft);
    rsp_t r;
    r                      = '0;
    r.status               = st;
    r.running_task         = rt;
    r.running_valid        = rv;
    r.result_task          = task_id;
    r.result_state         = 2'(qs);
    r.result_deadline_left = dleft;
    r.result_deadline_init = dinit;
    r.result_sleep_left    = sleft;
    return r;
  endfunction

  function automatic call_t row(logic [3:0] kind, logic [3:0] tgt, logic [15:0] dl,
                                logic [15:0] sl);
    call_t c;
    c.kind  = kind;
    c.tgt   = tgt;
    c.dl    = dl;
    c.sl    = sl;
    c.fixed = 1'b0;
    c.want  = '0;
    return c;
  endfunction

  function automatic call_t row_fixed(logic [3:0] kind, logic [3:0] tgt, logic [15:0] dl,
                                      logic [15:0] sl, rsp_t want);
    call_t c;
    c       = row(kind, tgt, dl, sl);
    c.fixed = 1'b1;
    c.want  = want;
    return c;
  endfunction

  function automatic logic [15:0] random_time();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    if (pick <= 3) return 16'($urandom_range(1, 4));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic call_t random_call();
    call_t c;
    idx_t  live[$];
    int    pick;
    c    = row(REQ_INFO, '0, random_time(), '0);
    pick = $urandom_range(99);
    if (pick < 26)      c.kind = REQ_CREATE;
    else if (pick < 46) c.kind = REQ_SCHEDULE;
    else if (pick < 60) c.kind = REQ_EXIT;
    else if (pick < 68) c.kind = REQ_YIELD;
    else if (pick < 78) c.kind = REQ_SET_DEADLINE;
    else if (pick < 90) c.kind = REQ_INFO;
    else if (pick < 93) c.kind = REQ_SLEEP;
    else if (pick < 95) c.kind = REQ_PERIOD_YIELD;
    else if (pick < 96) c.kind = REQ_START;
    else                c.kind = 4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    for (int i = 0; i < TASK_SLOTS; i++)
      if (slot_st[i] != ST_DORMANT) live.push_back(idx_t'(i));
    if (live.size() > 0 && $urandom_range(3) != 0)
      c.tgt = 4'(live[$urandom_range(live.size() - 1)]);
    else
      c.tgt = 4'($urandom_range(15));
    c.sl = $urandom_range(1) ? 16'd0 : random_time();
    return c;
  endfunction

  task automatic send_call(input call_t c);
    rsp_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= c.kind;
    req.target_task <= c.tgt;
    req.deadline_ms <= c.dl;
    req.sleep_ms    <= c.sl;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    compute_call_result(c, want);
    if (c.fixed) want = c.want;
    pending_results.push_back(want);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // response side
  initial begin
    rsp.ready    <= 1'b0;
    rx_hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req  = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: transaction on response channel with nothing pending", $time);
        errors++;
      end else begin
        head = pending_results.pop_front();
        compare_field("status", 16'(head.status), 16'(rsp.status));
        compare_field("running_task", 16'(head.running_task), 16'(rsp.running_task));
        compare_field("running_valid", 16'(head.running_valid), 16'(rsp.running_valid));
        compare_field("preempt", 16'(head.preempt), 16'(rsp.preempt));
        compare_field("resched_wanted", 16'(head.resched_wanted), 16'(rsp.resched_wanted));
        compare_field("result_task", 16'(head.result_task), 16'(rsp.result_task));
        compare_field("result_state", 16'(head.result_state), 16'(rsp.result_state));
        compare_field("result_deadline_left", head.result_deadline_left,
                      rsp.result_deadline_left);
        compare_field("result_deadline_init", head.result_deadline_init,
                      rsp.result_deadline_init);
        compare_field("result_sleep_left", head.result_sleep_left, rsp.result_sleep_left);
      end
    end
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("edf_task_scheduler_table_core verification failed");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    req.valid       <= 1'b0;
    req.req_type    <= REQ_CREATE;
    req.target_task <= '0;
    req.deadline_ms <= '0;
    req.sleep_ms    <= '0;
    errors       = 0;
    rx_hold_req  = 0;
    tx_idle_pct  = 15;
    rx_idle_pct  = 88;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_st[i] = ST_DORMANT;
      dl_left[i] = TIME_ONES;
      dl_init[i] = TIME_ONES;
      sl_left[i] = TIME_ONES;
    end
    cur_slot  = '0;
    cur_known = 1'b0;
    started   = 1'b0;

    // calls before start, bad codes and targets, then the start sequence
    script.push_back(row_fixed(REQ_SCHEDULE, 4'd0, 16'd10, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_YIELD, 4'd0, 16'd10, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_PERIOD_YIELD, 4'd0, 16'd10, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_SLEEP, 4'd0, 16'd10, 16'hFFFF,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_EXIT, 4'd0, 16'd10, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_UNUSED_HI, 4'hF, 16'hFFFF, 16'hFFFF,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_INFO, 4'd0, 16'd0, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_CREATE, 4'd0, 16'd0, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_CREATE, 4'd0, 16'hFFFF, 16'd0,
                               reply(1'b0, 4'd0, 1'b0, 4'd1, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_CREATE, 4'd0, 16'd1, 16'd0,
                               reply(1'b0, 4'd0, 1'b0, 4'd2, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_SET_DEADLINE, 4'd0, 16'd5, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_SET_DEADLINE, 4'd1, 16'd0, 16'd0,
                               reply(1'b1, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_SET_DEADLINE, 4'd1, 16'd500, 16'd0,
                               reply(1'b0, 4'd0, 1'b0, 4'd0, ST_DORMANT, '0, '0, '0)));
    script.push_back(row_fixed(REQ_INFO, 4'd1, 16'd0, 16'd0,
                               reply(1'b0, 4'd0, 1'b0, 4'd1, ST_READY, 16'd500, 16'd500,
                                     16'hFFFF)));
    script.push_back(row(REQ_START, 4'd0, 16'd0, 16'd0));
    script.push_back(row_fixed(REQ_START, 4'd0, 16'd0, 16'd0,
                               reply(1'b1, 4'd2, 1'b1, 4'd0, ST_DORMANT, '0, '0, '0)));
    // deadline tie with a higher index, then with a lower one
    script.push_back(row(REQ_CREATE, 4'd0, 16'd1, 16'd0));
    script.push_back(row(REQ_SET_DEADLINE, 4'd1, 16'd1, 16'd0));
    script.push_back(row(REQ_SLEEP, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_EXIT, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_SCHEDULE, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_EXIT, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_SCHEDULE, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_EXIT, 4'd0, 16'd0, 16'd0));
    // idle fallback, idle sleep, idle exit with the table empty
    script.push_back(row(REQ_SCHEDULE, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_SLEEP, 4'd0, 16'd0, 16'd7));
    script.push_back(row(REQ_EXIT, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_SCHEDULE, 4'd0, 16'd0, 16'd0));
    script.push_back(row(REQ_INFO, 4'd0, 16'd0, 16'd0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_call(script[i]);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 88;
        end
        1: begin
          tx_idle_pct = 88;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          rx_hold_req = HOLD_CYCLES;
        end
      endcase
      for (int n = 0; n < PHASE_CALLS; n++) send_call(random_call());
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("edf_task_scheduler_table_core verification clean");
    end else begin
      $display("edf_task_scheduler_table_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
